/* hdl/assert_macros.svh */
// assertion macros shared by the spring force vector rtl
// expects clk and rst_n (active low) in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SFV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled while in reset
`define SFV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* hdl/sfv_pkg.sv */
// shared types and constants of the spring force vector core
// no dependencies
`default_nettype none

package sfv_pkg;

  localparam int CoordW   = 32;
  localparam int DiffW    = 33;
  localparam int SqW      = 66;
  localparam int RadW     = 68;
  localparam int RootW    = 34;
  localparam int RestW    = 31;
  localparam int RangeW   = 18;
  localparam int ElastW   = 32;
  localparam int DenW     = 49;
  localparam int PeW      = 66;
  localparam int ProdW    = 115;
  localparam int MagQW    = 47;
  localparam int FracW    = 16;
  localparam int MagW     = 31;
  localparam int CompNumW = 64;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [RestW-1:0]  RestRst  = 31'd65536;
  localparam logic [RangeW-1:0] RangeRst = 18'd26214;
  localparam logic [ElastW-1:0] ElastRst = 32'd98304000;
  localparam logic [MagW-1:0]   MagCap   = 31'h7FFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REST  = 2'd0,
    CFG_RANGE = 2'd1,
    CFG_ELAST = 2'd2
  } cfg_idx_t;

  // per-axis magnitudes and direction signs
  typedef struct packed {
    logic [2:0][DiffW-1:0] ad;
    logic [2:0]            neg;
  } vec_t;

  // item context through the magnitude stages
  typedef struct packed {
    vec_t             vec;
    logic [RootW-1:0] len;
    logic             comp;
    logic             over;
  } pside_t;

  // context through the magnitude divider
  typedef struct packed {
    pside_t p;
    logic   sat;
  } msd_t;

  // context through the component dividers
  typedef struct packed {
    logic [2:0]       neg;
    logic [RootW-1:0] len;
    logic             over;
  } cside_t;

endpackage

`default_nettype wire

/* hdl/sfv_sqrt.sv */
// pipelined integer square root, one root bit per stage
// depends on sfv_pkg
`default_nettype none

module sfv_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sfv_pkg::RadW-1:0]  in_rad,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [sfv_pkg::RootW-1:0] out_root,
  output logic [SIDE_W-1:0]         out_side
);
  import sfv_pkg::*;

  logic              v_r    [RootW];
  logic [RadW-1:0]   rem_r  [RootW];
  logic [RootW-1:0]  root_r [RootW];
  logic [SIDE_W-1:0] side_r [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stg
    localparam int Bit = RootW - 1 - s;
    logic              v_in;
    logic [RadW-1:0]   rem_in;
    logic [RadW-1:0]   trial;
    logic [RadW-1:0]   rem_nxt;
    logic [RootW-1:0]  root_in;
    logic [RootW-1:0]  root_nxt;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // try this root bit against the remainder
    always_comb begin
      trial = (RadW'(root_in) << (Bit + 1)) | (RadW'(1) << (2 * Bit));
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (RootW'(1) << Bit);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[RootW-1];
  assign out_root  = root_r[RootW-1];
  assign out_side  = side_r[RootW-1];

endmodule

`default_nettype wire

/* hdl/sfv_div.sv */
// pipelined restoring divider, one quotient bit per stage, shared divisor
// expects num < den * 2**Q_W; depends on sfv_pkg only by convention
`default_nettype none

module sfv_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]           out_side
);
  localparam int TW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic                        v_r    [Q_W];
  logic [LANES-1:0][NUM_W-1:0] rem_r  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quo_r  [Q_W];
  logic [DEN_W-1:0]            den_r  [Q_W];
  logic [SIDE_W-1:0]           side_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    localparam int Bit = Q_W - 1 - s;
    logic                        v_in;
    logic [LANES-1:0][NUM_W-1:0] rem_in;
    logic [LANES-1:0][NUM_W-1:0] rem_nxt;
    logic [LANES-1:0][Q_W-1:0]   quo_in;
    logic [LANES-1:0][Q_W-1:0]   quo_nxt;
    logic [DEN_W-1:0]            den_in;
    logic [SIDE_W-1:0]           side_in;
    logic [TW-1:0]               trial;
    logic [TW-1:0]               rem_w;
    logic                        ge;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    // subtract the shifted divisor where it fits, per lane
    always_comb begin
      trial   = TW'(den_in) << Bit;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      rem_w   = '0;
      ge      = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        rem_w = TW'(rem_in[l]);
        ge    = (rem_w >= trial);
        if (ge) begin
          rem_nxt[l] = NUM_W'(rem_w - trial);
        end
        quo_nxt[l] = quo_in[l] | (Q_W'(ge) << Bit);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        den_r[s]  <= den_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

`default_nettype wire

/* hdl/spring_force_vector_core.sv */
// top level of the spring force vector core: distance, deformation, force
// depends on sfv_pkg, sfv_sqrt, sfv_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

//  channel   | direction | payload
//  in_       | slave     | six positions, 192 bits of tdata
//  out_      | master    | force xyz and span in tdata, overload in tuser
//  cfg_      | slave     | register index and write data, always ready
//
//  One request enters per cycle while the skid register is empty. The pipe has
//  3 front stages, 34 root stages, 5 magnitude stages, 47 divider stages,
//  2 scaling stages, 31 component divider stages and the output register.
//  The whole pipe advances together while the skid register is empty; a stalled
//  output fills the skid and then holds the pipe. Reset (synchronous, active low)
//  clears valid bits and restores register defaults.

module spring_force_vector_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z from bit 0 up
  input  logic [191:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // force_x, force_y, force_z, span from bit 0 up
  output logic [127:0]  out_tdata,
  // overload
  output logic [0:0]    out_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [sfv_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfv_pkg::CfgDataW-1:0] cfg_data
);
  import sfv_pkg::*;

  logic en;

  // configuration registers
  logic [RestW-1:0]  rest_r;
  logic [RangeW-1:0] range_r;
  logic [ElastW-1:0] elast_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= RestRst;
      range_r <= RangeRst;
      elast_r <= ElastRst;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REST:  rest_r  <= cfg_data[RestW-1:0];
        CFG_RANGE: range_r <= cfg_data[RangeW-1:0];
        CFG_ELAST: elast_r <= cfg_data[ElastW-1:0];
        default: ;
      endcase
    end
  end

  // front stage 1: coordinate differences and magnitudes
  logic              f1_v_r;
  vec_t              f1_vec_r, f1_vec_nxt;
  logic [DiffW-1:0]  f1_d;
  logic [CoordW-1:0] f1_a, f1_b;

  always_comb begin
    f1_vec_nxt = '0;
    f1_d       = '0;
    f1_a       = '0;
    f1_b       = '0;
    for (int i = 0; i < 3; i++) begin
      f1_a = in_tdata[CoordW*i +: CoordW];
      f1_b = in_tdata[CoordW*(i+3) +: CoordW];
      f1_d = {f1_b[CoordW-1], f1_b} - {f1_a[CoordW-1], f1_a};
      f1_vec_nxt.neg[i] = f1_d[DiffW-1];
      f1_vec_nxt.ad[i]  = f1_d[DiffW-1] ? (DiffW'(0) - f1_d) : f1_d;
    end
  end

  // front stage 2: squares
  logic                      f2_v_r;
  vec_t                      f2_vec_r;
  logic [2:0][SqW-1:0]       f2_sq_r, f2_sq_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_sq_nxt[i] = SqW'(f1_vec_r.ad[i]) * SqW'(f1_vec_r.ad[i]);
    end
  end

  // front stage 3: sum of squares
  logic            f3_v_r;
  vec_t            f3_vec_r;
  logic [RadW-1:0] f3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_tvalid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_vec_r <= f1_vec_nxt;
      f2_vec_r <= f1_vec_r;
      f2_sq_r  <= f2_sq_nxt;
      f3_vec_r <= f2_vec_r;
      f3_sum_r <= RadW'(f2_sq_r[0]) + RadW'(f2_sq_r[1]) + RadW'(f2_sq_r[2]);
    end
  end

  // distance
  logic             sq_v;
  logic [RootW-1:0] sq_root;
  vec_t             sq_vec;

  sfv_sqrt #(
    .SIDE_W ($bits(vec_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f3_v_r),
    .in_rad    (f3_sum_r),
    .in_side   (f3_vec_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_vec)
  );

  // magnitude stage 1: deformation, range product, overload
  logic                  p1_comp, p1_over;
  logic [RootW-1:0]      p1_def;
  logic [DenW-1:0]       p1_den;
  logic [RootW+FracW-1:0] p1_num;
  logic                  p1_v_r;
  logic [RootW-1:0]      p1_def_r;
  logic [DenW-1:0]       p1_den_r, p1_dd_r;
  pside_t                p1_side_r;

  always_comb begin
    p1_comp = sq_root < RootW'(rest_r);
    p1_def  = p1_comp ? (RootW'(rest_r) - sq_root) : (sq_root - RootW'(rest_r));
    p1_den  = DenW'(rest_r) * DenW'(range_r);
    p1_num  = {p1_def, {FracW{1'b0}}};
    p1_over = (p1_den == '0) || (p1_num >= (RootW+FracW)'(p1_den));
  end

  // magnitude stages 2 to 5: def * elasticity * den, split products, cap check
  logic                 p2_v_r, p3_v_r, p4_v_r, p5_v_r;
  logic [PeW-1:0]       p2_pe_r;
  logic [DenW-1:0]      p2_den_r, p2_dd_r, p3_dd_r, p4_dd_r, p5_dd_r;
  pside_t               p2_side_r, p3_side_r, p4_side_r;
  logic [57:0]          p3_pp00_r, p3_pp10_r;
  logic [56:0]          p3_pp01_r, p3_pp11_r;
  logic [ProdW-1:0]     p4_prod_r, p5_prod_r;
  msd_t                 p5_side_r, p5_side_nxt;

  always_comb begin
    p5_side_nxt.p   = p4_side_r;
    p5_side_nxt.sat = p4_side_r.over ||
                      (p4_prod_r >= (ProdW'(p4_dd_r) << MagQW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= sq_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_def_r       <= p1_def;
      p1_den_r       <= p1_den;
      p1_dd_r        <= DenW'(p1_den - p1_num[DenW-1:0]);
      p1_side_r.vec  <= sq_vec;
      p1_side_r.len  <= sq_root;
      p1_side_r.comp <= p1_comp;
      p1_side_r.over <= p1_over;

      p2_pe_r   <= PeW'(p1_def_r) * PeW'(elast_r);
      p2_den_r  <= p1_den_r;
      p2_dd_r   <= p1_dd_r;
      p2_side_r <= p1_side_r;

      p3_pp00_r <= 58'(p2_pe_r[32:0])  * 58'(p2_den_r[24:0]);
      p3_pp01_r <= 57'(p2_pe_r[32:0])  * 57'(p2_den_r[48:25]);
      p3_pp10_r <= 58'(p2_pe_r[65:33]) * 58'(p2_den_r[24:0]);
      p3_pp11_r <= 57'(p2_pe_r[65:33]) * 57'(p2_den_r[48:25]);
      p3_dd_r   <= p2_dd_r;
      p3_side_r <= p2_side_r;

      p4_prod_r <= ProdW'(p3_pp00_r) + (ProdW'(p3_pp01_r) << 25) +
                   (ProdW'(p3_pp10_r) << 33) + (ProdW'(p3_pp11_r) << 58);
      p4_dd_r   <= p3_dd_r;
      p4_side_r <= p3_side_r;

      p5_prod_r <= p4_prod_r;
      p5_dd_r   <= p4_dd_r;
      p5_side_r <= p5_side_nxt;
    end
  end

  // raw magnitude divider
  logic                   md_v;
  logic [0:0][MagQW-1:0]  md_q;
  msd_t                   md_side;

  sfv_div #(
    .LANES  (1),
    .NUM_W  (ProdW),
    .DEN_W  (DenW),
    .Q_W    (MagQW),
    .SIDE_W ($bits(msd_t))
  ) u_mag_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p5_v_r),
    .in_num    (p5_prod_r),
    .in_den    (p5_dd_r),
    .in_side   (p5_side_r),
    .out_valid (md_v),
    .out_quo   (md_q),
    .out_side  (md_side)
  );

  // scaling stages: saturate magnitude, multiply by each axis
  logic                     m1_v_r, m2_v_r;
  logic [MagW-1:0]          m1_mag_r;
  logic [2:0][DiffW-1:0]    m1_ad_r;
  cside_t                   m1_cs_r, m2_cs_r;
  logic [2:0][CompNumW-1:0] m2_np_r, m2_np_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_np_nxt[i] = CompNumW'(m1_mag_r) * CompNumW'(m1_ad_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= md_v;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mag_r     <= md_side.sat ? MagCap : md_q[0][MagQW-1:FracW];
      m1_ad_r      <= md_side.p.vec.ad;
      m1_cs_r.neg  <= md_side.p.vec.neg ^ {3{md_side.p.comp}};
      m1_cs_r.len  <= md_side.p.len;
      m1_cs_r.over <= md_side.p.over;
      m2_np_r      <= m2_np_nxt;
      m2_cs_r      <= m1_cs_r;
    end
  end

  // component dividers, shared divisor is the distance
  logic                 cd_v;
  logic [2:0][MagW-1:0] cd_q;
  cside_t               cd_side;

  sfv_div #(
    .LANES  (3),
    .NUM_W  (CompNumW),
    .DEN_W  (RootW),
    .Q_W    (MagW),
    .SIDE_W ($bits(cside_t))
  ) u_comp_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m2_v_r),
    .in_num    (m2_np_r),
    .in_den    (m2_cs_r.len),
    .in_side   (m2_cs_r),
    .out_valid (cd_v),
    .out_quo   (cd_q),
    .out_side  (cd_side)
  );

  // result assembly: signs, zero distance, span saturation
  logic         fin_valid;
  logic [127:0] fin_data;
  logic [31:0]  fin_m;

  assign fin_valid = cd_v;

  always_comb begin
    fin_data = '0;
    fin_m    = '0;
    for (int i = 0; i < 3; i++) begin
      fin_m = (cd_side.len == '0) ? 32'd0 : {1'b0, cd_q[i]};
      fin_data[32*i +: 32] = cd_side.neg[i] ? (32'd0 - fin_m) : fin_m;
    end
    fin_data[127:96] = (cd_side.len[RootW-1:32] != '0) ? 32'hFFFF_FFFF
                                                       : cd_side.len[31:0];
  end

  // output register with skid
  logic         out_valid_r, sk_valid_r;
  logic [127:0] out_data_r, sk_data_r;
  logic         out_over_r, sk_over_r;

  assign en        = !sk_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= fin_valid;
      end
    end else if (en && fin_valid) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (sk_valid_r) begin
        out_data_r <= sk_data_r;
        out_over_r <= sk_over_r;
      end else begin
        out_data_r <= fin_data;
        out_over_r <= cd_side.over;
      end
    end else if (en) begin
      sk_data_r <= fin_data;
      sk_over_r <= cd_side.over;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_over_r;

  // skid only ever holds a request behind a waiting output
  `SFV_ASSERT_IMPL(a_skid_behind_out, sk_valid_r, out_valid_r)
  // a waiting skid entry survives until the output drains
  `SFV_ASSERT_NEXT(a_skid_kept, sk_valid_r && !out_tready, sk_valid_r)
  // a finished request arriving at a blocked output lands in the skid
  `SFV_ASSERT_NEXT(a_stall_to_skid, fin_valid && en && out_valid_r && !out_tready,
                   sk_valid_r)

endmodule

`default_nettype wire

/* dv/spring_force_checker.sv */
// result checker for the spring force vector core: predicts each force vector
// from the accepted positions and the register settings, compares the outputs
// depends on sfv_pkg
`timescale 1ns / 100ps

module spring_force_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [191:0]                 in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [127:0]                 out_tdata,
  input  logic [0:0]                   out_tuser,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sfv_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfv_pkg::CfgDataW-1:0] cfg_data,
  output int                           pending,
  output int                           errors
);
  import sfv_pkg::*;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [31:0] span;
    logic        overload;
  } force_t;

  logic [RestW-1:0]  rest_len;
  logic [RangeW-1:0] def_range;
  logic [ElastW-1:0] elast;
  force_t            force_q[$];

  // exact force of one spring in the block's fixed point
  function automatic force_t spring_force(logic [191:0] pos);
    logic signed [32:0] d [3];
    logic [32:0]        ad [3];
    logic [67:0]        sq_sum;
    logic [67:0]        trial;
    logic [135:0]       sq;
    logic [33:0]        len;
    logic [33:0]        deform;
    logic [48:0]        den;
    logic [49:0]        num;
    logic [127:0]       prod;
    logic [127:0]       quot;
    logic [30:0]        mag;
    logic [63:0]        comp;
    logic               shrunk;
    logic               over;
    logic [31:0]        f [3];
    force_t             r;
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(pos[32*(i+3) +: 32]) - $signed(pos[32*i +: 32]);
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      sq_sum = sq_sum + ad[i] * ad[i];
    end
    // bitwise integer square root
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = {34'd0, len} | (68'd1 << b);
      sq = trial * trial;
      if (sq <= sq_sum) len = trial[33:0];
    end
    shrunk = len < rest_len;
    deform = shrunk ? rest_len - len : len - rest_len;
    den = rest_len * def_range;
    num = {deform, 16'd0};
    over = (den == 0) || (num >= den);
    if (over) begin
      mag = MagCap;
    end else begin
      prod = deform * elast * den;
      quot = prod / (den - num);
      quot = quot >> 16;
      mag = (quot > MagCap) ? MagCap : quot[30:0];
    end
    for (int i = 0; i < 3; i++) begin
      comp = (len == 0) ? 64'd0 : (mag * ad[i]) / len;
      f[i] = ((d[i] < 0) != shrunk) ? -comp[31:0] : comp[31:0];
    end
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    r.span = (len > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
    r.overload = over;
    return r;
  endfunction

  assign pending = force_q.size();

  always @(posedge clk) begin
    force_t want;
    force_t got;
    if (!rst_n) begin
      rest_len <= RestRst;
      def_range <= RangeRst;
      elast <= ElastRst;
      force_q.delete();
      errors <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REST:  rest_len <= cfg_data[RestW-1:0];
          CFG_RANGE: def_range <= cfg_data[RangeW-1:0];
          CFG_ELAST: elast <= cfg_data;
          default: ;
        endcase
      end
      // accepted request
      if (in_tvalid && in_tready) force_q.push_back(spring_force(in_tdata));
      // accepted result
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
               out_tdata[127:96], out_tuser[0]};
        if (force_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = force_q.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("mismatch fx %h/%h fy %h/%h fz %h/%h span %h/%h ovl %b/%b",
                       want.fx, got.fx, want.fy, got.fy, want.fz, got.fz,
                       want.span, got.span, want.overload, got.overload);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* dv/testbench.sv */
// stimulus and verdict for the spring force vector core
// depends on sfv_pkg, spring_force_vector_core and spring_force_checker
`timescale 1ns / 100ps

module testbench;
  import sfv_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int Drain = 140;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [191:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [127:0]  out_tdata;
  logic [0:0]    out_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int            pending;
  int            errors;
  logic          quiet = 1'b0;
  logic [31:0]   rest_now = 32'd65536;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spring_force_vector_core i_dut (.*);

  spring_force_checker i_checker (.*);

  // random backpressure on results
  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
  end

  // one position request, with an occasional gap in front; valid stays up
  // afterwards so requests can follow back to back
  task automatic send_positions(logic [191:0] pos);
    logic taken;
    if (!quiet && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pos;
    do begin
      taken = in_tready;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == CFG_REST) rest_now = {1'b0, val[30:0]};
    @(negedge clk);
  endtask

  // wait until every force vector is back and the pipe is empty
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  function automatic logic [191:0] pack_pair(logic [31:0] a [3], logic [31:0] b [3]);
    return {b[2], b[1], b[0], a[2], a[1], a[0]};
  endfunction

  // mostly springs near the rest length, some fully random positions
  function automatic logic [191:0] random_spring();
    logic [31:0] a [3];
    logic [31:0] b [3];
    longint      reach;
    reach = (rest_now == 0) ? 64'd1 << 20 : longint'(rest_now);
    if (reach > 64'd1 << 30) reach = 64'd1 << 30;
    for (int i = 0; i < 3; i++) begin
      a[i] = $urandom;
      if ($urandom_range(3) == 0) b[i] = $urandom;
      else b[i] = a[i] + 32'(longint'($urandom_range(0, 2 * reach)) - reach);
    end
    return pack_pair(a, b);
  endfunction

  task automatic directed_springs();
    logic [31:0] a [3];
    logic [31:0] b [3];
    // coincident masses
    a = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF};
    send_positions(pack_pair(a, a));
    // opposite corners, span saturates
    a = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    b = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_positions(pack_pair(a, b));
    send_positions(pack_pair(b, a));
    // exactly at rest length on each axis
    a = '{32'd0, 32'd0, 32'd0};
    b = '{32'd65536, 32'd0, 32'd0};
    send_positions(pack_pair(a, b));
    b = '{32'd0, -32'd65536, 32'd0};
    send_positions(pack_pair(a, b));
    b = '{32'd0, 32'd0, 32'd65536};
    send_positions(pack_pair(a, b));
    // slight stretch and compression, mixed signs
    b = '{32'd50000, -32'd45000, 32'd10000};
    send_positions(pack_pair(a, b));
    b = '{-32'd30000, 32'd20000, -32'd15000};
    send_positions(pack_pair(a, b));
    // factor at zero and past the limit, stretched and compressed
    b = '{32'd91750, 32'd0, 32'd0};
    send_positions(pack_pair(a, b));
    b = '{32'd91751, 32'd0, 32'd0};
    send_positions(pack_pair(a, b));
    b = '{32'd39322, 32'd0, 32'd0};
    send_positions(pack_pair(a, b));
    // very short spring, heavily compressed
    b = '{32'd1, 32'd1, 32'd0};
    send_positions(pack_pair(a, b));
  endtask

  task automatic random_springs(int count, bit with_quiet);
    for (int n = 0; n < count; n++) begin
      quiet = with_quiet && (n >= 100) && (n < 300);
      send_positions(random_spring());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset
    directed_springs();
    random_springs(450, 1'b1);
    drain_pipe();

    // largest rest length and elasticity, a wide range, plus a write to an unused index
    write_reg(CfgUnused, $urandom);
    write_reg(CFG_REST, 32'hFFFF_FFFF);
    write_reg(CFG_RANGE, 32'd131072);
    write_reg(CFG_ELAST, 32'hFFFF_FFFF);
    random_springs(450, 1'b0);
    drain_pipe();

    // degenerate settings: zero rest length, zero elasticity, smallest nonzero range
    write_reg(CFG_REST, 32'd0);
    write_reg(CFG_RANGE, 32'd1);
    write_reg(CFG_ELAST, 32'd0);
    random_springs(150, 1'b0);
    drain_pipe();

    // tiny rest length with the smallest nonzero range
    write_reg(CFG_REST, 32'd1);
    random_springs(100, 1'b0);
    drain_pipe();

    // mid-range settings
    write_reg(CFG_REST, $urandom_range(32'h7FFF_FFFF, 32'd4096));
    write_reg(CFG_RANGE, $urandom_range(131072, 1));
    write_reg(CFG_ELAST, $urandom);
    random_springs(450, 1'b1);
    drain_pipe();

    // short spring, stiff and wide range
    write_reg(CFG_REST, 32'd300);
    write_reg(CFG_RANGE, 32'd70000);
    write_reg(CFG_ELAST, $urandom);
    random_springs(400, 1'b0);
    drain_pipe();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(12 * 400_000);
    $display("FAILURE");
    $finish;
  end

endmodule
